// File: design/natg_pkg.sv
// shared constants for the nice axis tick generator
// no dependencies

package natg_pkg;

  // fixed field widths of the stream payloads and the target register
  localparam int unsigned IN_FIELD_W = 32;
  localparam int unsigned TICK_W = 40;
  localparam int unsigned STEP_W = 33;
  localparam int unsigned TT_W = 6;

  // default span width and register limits
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam logic [TT_W-1:0] TT_RESET = 6'd5;
  localparam logic [TT_W-1:0] TT_MIN = 6'd2;
  localparam logic [TT_W-1:0] TT_MAX = 6'd32;

  // result count limit per transfer in
  localparam int unsigned MAX_TICKS = 64;
  localparam int unsigned CNT_W = 6;

  // padded payload widths
  localparam int unsigned IN_DATA_W = 2 * IN_FIELD_W;
  localparam int unsigned OUT_DATA_W = ((TICK_W + STEP_W + 7) / 8) * 8;

endpackage

// File: design/nice_axis_tick_generator_core.sv
// Nice axis tick generator: one span in, a run of nice tick positions out.
// An input transfer is followed by a search for the power of ten (one decade per
// cycle), the nice range, a second decade search for the step, then two bit-serial
// remainder divisions to snap both ends onto the step grid. After that one tick leaves
// per cycle while the output side takes them. A reversed span gives a single result
// flagged in out_tuser. Spans are read as VALUE_WIDTH-bit signed values when
// VALUE_WIDTH is at most 32, else as unsigned 32-bit values.

module nice_axis_tick_generator_core
  import natg_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg: target_ticks
  input  logic                  cfg_wr_en,
  input  logic [TT_W-1:0]       cfg_wr_data,
  // in_tdata: span_low [31:0], span_high [63:32]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: tick_value [39:0], tick_step [72:40], zero pad above
  // out_tuser: error
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int unsigned MW = VALUE_WIDTH + 10;
  localparam int unsigned SW = MW + 1;
  localparam int unsigned XW = MW + 4;
  localparam int unsigned IN_W = (VALUE_WIDTH < IN_FIELD_W) ? VALUE_WIDTH : IN_FIELD_W;
  localparam bit IN_SIGNED = (VALUE_WIDTH <= IN_FIELD_W);
  localparam int unsigned DC_W = $clog2(MW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_PWR, S_RANGE, S_PE, S_STEP, S_DIVLO, S_DIVHI, S_EMIT
  } state_t;

  state_t                 state_r;
  logic [TT_W-1:0]        tt_r;
  logic signed [SW-1:0]   lo_r, hi_r, cur_r, gmax_r;
  logic [MW-1:0]          width_r, p_r, nr_r, pd_r, pe_r, step_r;
  logic [MW-1:0]          dvd_r, rem_r;
  logic [DC_W-1:0]        dcnt_r;
  logic [CNT_W-1:0]       k_r;
  logic                   out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [TICK_W-1:0]      tick_r;
  logic [STEP_W-1:0]      ostep_r;
  logic                   out_load;

  // span ends read as IN_W-bit values, signed only when VALUE_WIDTH fits the field
  logic signed [SW-1:0] lo_in, hi_in, diff;
  always_comb begin
    if (IN_SIGNED) begin
      lo_in = SW'($signed(in_tdata[IN_W-1:0]));
      hi_in = SW'($signed(in_tdata[IN_FIELD_W+IN_W-1:IN_FIELD_W]));
    end else begin
      lo_in = SW'($signed({1'b0, in_tdata[IN_W-1:0]}));
      hi_in = SW'($signed({1'b0, in_tdata[IN_FIELD_W+IN_W-1:IN_FIELD_W]}));
    end
    diff = hi_in - lo_in;
  end

  // decade steps and nice thresholds
  logic [XW-1:0] p10, pd10, px, p2, p5, wx, nrx, pdx, pd3, pd7, nr2;
  logic [TT_W-1:0] tt_cl;
  always_comb begin
    px   = XW'(p_r);
    p10  = (px << 3) + (px << 1);
    p2   = px << 1;
    p5   = (px << 2) + px;
    wx   = XW'(width_r);
    pdx  = XW'(pd_r);
    pd10 = (pdx << 3) + (pdx << 1);
    pd3  = (pdx << 1) + pdx;
    pd7  = (pdx << 3) - pdx;
    nrx  = XW'(nr_r);
    nr2  = nrx << 1;
    if (tt_r < TT_MIN) tt_cl = TT_MIN;
    else if (tt_r > TT_MAX) tt_cl = TT_MAX;
    else tt_cl = tt_r;
  end

  // one restoring division step on the remainder
  logic [MW:0]   trial;
  logic [MW-1:0] rem_nxt;
  always_comb begin
    trial = {rem_r, dvd_r[MW-1]};
    if (trial >= {1'b0, step_r}) rem_nxt = MW'(trial - {1'b0, step_r});
    else rem_nxt = trial[MW-1:0];
  end

  // grid ends from the final remainders
  logic signed [SW-1:0] rem_s, step_s, gmin_c, gmax_c;
  logic                 tick_last;
  always_comb begin
    rem_s  = SW'($signed({1'b0, rem_nxt}));
    step_s = SW'($signed({1'b0, step_r}));
    if (!lo_r[SW-1]) gmin_c = lo_r - rem_s;
    else if (rem_nxt == '0) gmin_c = lo_r;
    else gmin_c = lo_r + rem_s - step_s;
    if (hi_r[SW-1]) gmax_c = hi_r + rem_s;
    else if (rem_nxt == '0) gmax_c = hi_r;
    else gmax_c = hi_r + step_s - rem_s;
    tick_last = (cur_r == gmax_r) || (k_r == CNT_W'(MAX_TICKS - 1));
  end

  // output register loads a result when it is free or being emptied
  assign out_load = ((state_r == S_ERR) || (state_r == S_EMIT)) &&
                    (!out_tvalid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = OUT_DATA_W'({ostep_r, tick_r});

  // control sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tt_r         <= TT_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tt_r <= cfg_wr_data;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lo_r <= lo_in;
            hi_r <= hi_in;
            if (diff[SW-1]) begin
              state_r <= S_ERR;
            end else begin
              width_r <= (diff == '0) ? MW'(1) : MW'(diff);
              p_r     <= MW'(1);
              state_r <= S_PWR;
            end
          end
        end
        S_ERR: begin
          if (!out_tvalid_r || out_tready) begin
            out_tuser_r  <= 1'b1;
            out_tlast_r  <= 1'b1;
            tick_r       <= '0;
            ostep_r      <= '0;
            state_r      <= S_IDLE;
          end
        end
        S_PWR: begin
          if (p10 <= wx) p_r <= MW'(p10);
          else state_r <= S_RANGE;
        end
        S_RANGE: begin
          if (wx <= px) nr_r <= MW'(px);
          else if (wx <= p2) nr_r <= MW'(p2);
          else if (wx <= p5) nr_r <= MW'(p5);
          else nr_r <= MW'(p10);
          pd_r    <= MW'(tt_cl - TT_W'(1));
          pe_r    <= MW'(1);
          state_r <= S_PE;
        end
        S_PE: begin
          if (pd10 <= nrx) begin
            pd_r <= MW'(pd10);
            pe_r <= MW'((XW'(pe_r) << 3) + (XW'(pe_r) << 1));
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (nr2 < pd3) step_r <= pe_r;
          else if (nrx < pd3) step_r <= MW'(XW'(pe_r) << 1);
          else if (nrx < pd7) step_r <= MW'((XW'(pe_r) << 2) + XW'(pe_r));
          else step_r <= MW'((XW'(pe_r) << 3) + (XW'(pe_r) << 1));
          dvd_r   <= lo_r[SW-1] ? MW'(-lo_r) : MW'(lo_r);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIVLO;
        end
        S_DIVLO: begin
          if (dcnt_r == DC_W'(MW - 1)) begin
            cur_r   <= gmin_c;
            dvd_r   <= hi_r[SW-1] ? MW'(-hi_r) : MW'(hi_r);
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIVHI;
          end else begin
            rem_r  <= rem_nxt;
            dvd_r  <= dvd_r << 1;
            dcnt_r <= dcnt_r + DC_W'(1);
          end
        end
        S_DIVHI: begin
          if (dcnt_r == DC_W'(MW - 1)) begin
            gmax_r  <= gmax_c;
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            rem_r  <= rem_nxt;
            dvd_r  <= dvd_r << 1;
            dcnt_r <= dcnt_r + DC_W'(1);
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tuser_r  <= 1'b0;
            out_tlast_r  <= tick_last;
            tick_r       <= TICK_W'(cur_r);
            ostep_r      <= STEP_W'(step_r);
            cur_r        <= cur_r + SW'($signed({1'b0, step_r}));
            k_r          <= k_r + CNT_W'(1);
            if (tick_last) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // an error transfer always closes its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error result without tlast");

  // a tick carries a non-zero step
  a_step_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[TICK_W+STEP_W-1:TICK_W] != '0)
    else $error("tick with zero step");

  // an accepted span is worked on before the next one is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // pad bits above the step stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:TICK_W+STEP_W] == '0)
    else $error("non-zero pad bits");
`endif

endmodule

// File: verif/tb_nice_axis_tick_generator_core.sv
// testbench for the nice axis tick generator core: spans in, tick runs out
// depends on natg_pkg and nice_axis_tick_generator_core; self-checking, no files read
`timescale 1ns / 1ps

module tb_nice_axis_tick_generator_core;
  import natg_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned ITEM_LAT = 2 * (VW + 10) + 2 * 16 + 4 + 80;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [STEP_W-1:0] step;
    logic              err;
    logic              last;
  } tick_rec_t;

  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        has_exp;
    tick_rec_t   exp0;
  } span_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [TT_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  // predictor copy of the register
  logic [TT_W-1:0] target_ticks;
  tick_rec_t tick_queue[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  longint unsigned cycle_count = 0;
  bit hold_req = 1'b0;
  int unsigned hold_cycles = 0;

  always #5 clk = ~clk;

  nice_axis_tick_generator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  function automatic longint floor_mult(input longint a, input longint s);
    longint q;
    q = a / s;
    if ((a % s) != 0 && a < 0) q--;
    return q * s;
  endfunction

  function automatic longint ceil_mult(input longint a, input longint s);
    longint q;
    q = a / s;
    if ((a % s) != 0 && a > 0) q++;
    return q * s;
  endfunction

  // nice-number tick run for one span, pushed onto the expected queue
  task automatic predict_ticks(input logic [31:0] lo_raw, input logic [31:0] hi_raw);
    longint lo, hi, gmin, gmax, cnt, cur;
    longint unsigned width, p, nrange, dv, pe, step;
    tick_rec_t r;
    lo = longint'($signed(lo_raw));
    hi = longint'($signed(hi_raw));
    if (hi < lo) begin
      r = '{tick: '0, step: '0, err: 1'b1, last: 1'b1};
      tick_queue.push_back(r);
      return;
    end
    width = longint'(hi - lo);
    if (width == 0) width = 1;
    p = 1;
    while (p * 10 <= width) p *= 10;
    if (width <= p) nrange = p;
    else if (width <= 2 * p) nrange = 2 * p;
    else if (width <= 5 * p) nrange = 5 * p;
    else nrange = 10 * p;
    dv = target_ticks;
    if (dv < 2) dv = 2;
    if (dv > 32) dv = 32;
    dv -= 1;
    pe = 1;
    while (pe * 10 * dv <= nrange) pe *= 10;
    if (2 * nrange < 3 * pe * dv) step = pe;
    else if (nrange < 3 * pe * dv) step = 2 * pe;
    else if (nrange < 7 * pe * dv) step = 5 * pe;
    else step = 10 * pe;
    gmin = floor_mult(lo, longint'(step));
    gmax = ceil_mult(hi, longint'(step));
    cnt = (gmax - gmin) / longint'(step) + 1;
    if (cnt > MAX_TICKS) cnt = MAX_TICKS;
    cur = gmin;
    for (longint k = 0; k < cnt; k++) begin
      r.tick = cur[TICK_W-1:0];
      r.step = step[STEP_W-1:0];
      r.err = 1'b0;
      r.last = (k == cnt - 1);
      tick_queue.push_back(r);
      cur += longint'(step);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tick_rec_t w;
      results_seen++;
      if (tick_queue.size() == 0) begin
        fail_count++;
        $display("unexpected result transfer %h", out_tdata);
      end else begin
        w = tick_queue.pop_front();
        if (out_tdata[TICK_W-1:0] !== w.tick)
          report_mismatch("tick_value", 64'(out_tdata[TICK_W-1:0]), 64'(w.tick));
        if (out_tdata[TICK_W+STEP_W-1:TICK_W] !== w.step)
          report_mismatch("tick_step", 64'(out_tdata[TICK_W+STEP_W-1:TICK_W]), 64'(w.step));
        if (out_tuser !== w.err) report_mismatch("error", 64'(out_tuser), 64'(w.err));
        if (out_tlast !== w.last) report_mismatch("last", 64'(out_tlast), 64'(w.last));
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cycles == 0) hold_cycles <= 600;
    else if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cycles > 1) out_tready <= 1'b0;
    else if (cycle_count[9]) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_span(input logic [31:0] lo, input logic [31:0] hi);
    in_tdata <= {hi, lo};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ticks(lo, hi);
  endtask

  // burst of spans with random gaps between bursts
  task automatic send_burst(input logic [31:0] lo, input logic [31:0] hi,
                            input bit end_of_burst);
    send_span(lo, hi);
    if (end_of_burst) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (tick_queue.size() != 0) @(posedge clk);
    repeat (ITEM_LAT) @(posedge clk);
  endtask

  task automatic write_target(input logic [TT_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    target_ticks = v;
    @(posedge clk);
  endtask

  // random span: mostly modest widths, some full range and reversed
  task automatic rand_span(output logic [31:0] lo, output logic [31:0] hi);
    int unsigned sel;
    longint l, w;
    sel = $urandom_range(0, 9);
    lo = $urandom;
    if (sel < 6) begin
      l = longint'($signed(lo));
      w = longint'($urandom_range(0, 1 << $urandom_range(0, 31)));
      if (l + w > 2147483647) l = 2147483647 - w;
      lo = l[31:0];
      hi = 32'(l + w);
    end else if (sel < 8) begin
      hi = $urandom;
      if ($signed(hi) < $signed(lo)) begin
        hi ^= lo; lo ^= hi; hi ^= lo;
      end
    end else begin
      hi = $urandom;
    end
  endtask

  span_row_t span_table[] = '{
    '{32'd0, 32'd0, 1'b1, '{tick: 40'd0, step: 33'd1, err: 1'b0, last: 1'b1}},
    '{32'd5, 32'd4, 1'b1, '{tick: 40'd0, step: 33'd0, err: 1'b1, last: 1'b1}},
    '{32'h7fffffff, 32'h80000000, 1'b1, '{tick: '0, step: '0, err: 1'b1, last: 1'b1}},
    '{32'h80000000, 32'h7fffffff, 1'b0, '{default: '0}},
    '{32'h80000000, 32'h80000000, 1'b0, '{default: '0}},
    '{32'h7fffffff, 32'h7fffffff, 1'b0, '{default: '0}},
    '{32'hffffffff, 32'd1, 1'b0, '{default: '0}},
    '{32'd0, 32'd100, 1'b0, '{default: '0}},
    '{32'hfffffc18, 32'd17, 1'b0, '{default: '0}},
    '{32'd123, 32'd9876, 1'b0, '{default: '0}},
    '{32'h55555555, 32'h5aaaaaaa, 1'b0, '{default: '0}},
    '{32'haaaaaaaa, 32'hd5555555, 1'b0, '{default: '0}}
  };
  logic [TT_W-1:0] target_plan[] = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd1, 6'd33, 6'd11};

  initial begin
    logic [31:0] lo, hi;
    target_ticks = TT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed spans at the reset target
    foreach (span_table[i]) begin
      if (span_table[i].has_exp) begin
        send_span(span_table[i].lo, span_table[i].hi);
        void'(tick_queue.pop_back());
        tick_queue.push_back(span_table[i].exp0);
      end else begin
        send_span(span_table[i].lo, span_table[i].hi);
      end
    end
    drain_and_idle();

    // long receiver hold-off while spans keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) begin
      rand_span(lo, hi);
      send_span(lo, hi);
    end
    hold_req = 1'b0;
    drain_and_idle();

    // random phases across register settings, extremes included
    foreach (target_plan[t]) begin
      write_target(target_plan[t]);
      send_span(32'h80000000, 32'h7fffffff);
      send_span(32'd0, 32'd0);
      for (int i = 0; i < 15; i++) begin
        rand_span(lo, hi);
        send_burst(lo, hi, $urandom_range(0, 2) == 0);
      end
      drain_and_idle();
    end

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
design/natg_pkg.sv
design/nice_axis_tick_generator_core.sv
verif/tb_nice_axis_tick_generator_core.sv
